>>> design/assert_macros.svh
// Assertion macros shared by the course walker RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

>>> design/bbcw_pkg.sv
// Types and constants for the brick bond course walker.
// No dependencies.
package bbcw_pkg;
	localparam logic [2:0] ST_UNIT       = 3'd0;
	localparam logic [2:0] ST_BAD_EXTENT = 3'd1;
	localparam logic [2:0] ST_BAD_UNIT   = 3'd2;
	localparam logic [2:0] ST_CAP        = 3'd3;
	localparam logic [2:0] ST_ABOVE      = 3'd4;
	localparam logic [2:0] ST_EMPTY      = 3'd5;

	localparam logic [2:0] REG_BOND   = 3'd0;
	localparam logic [2:0] REG_LENGTH = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_DEPTH  = 3'd3;
	localparam logic [2:0] REG_JOINT  = 3'd4;
	localparam logic [2:0] REG_MAXU   = 3'd5;

	localparam logic [1:0] BOND_STACK    = 2'd0;
	localparam logic [1:0] BOND_RUNNING  = 2'd1;
	localparam logic [1:0] BOND_ENGLISH  = 2'd2;
	localparam logic [1:0] BOND_FLEMISH  = 2'd3;

	typedef struct packed {
		logic [11:0] course_number;
		logic [14:0] wall_half_length;
		logic [14:0] wall_half_height;
		logic [14:0] wall_half_depth;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [11:0]        course_out;
		logic [5:0]         unit_index;
		logic signed [15:0] span_start;
		logic [15:0]        span_length;
		logic signed [15:0] center_height;
		logic               is_header;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;
endpackage

>>> design/bbcw_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses bbcw_pkg.
module bbcw_divider
	import bbcw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [17:0] trial;

	assign trial = {rem_q, quo_q[15]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q};

	`include "assert_macros.svh"
	`CHK_NEXT(a_div_busy, clk, arst_n, req.start, busy_q)
	`CHK_IMPL(a_div_done, clk, arst_n, rsp.done, !busy_q)
endmodule

>>> design/brick_bond_course_walker_unit.sv
// Brick bond course walker top level: sequencer, registers and output stage.
// Uses bbcw_pkg, bbcw_divider and assert_macros.svh.
//
// One input item lays one course. After acceptance the block makes the extent
// and unit checks, runs the serial course-count divider and its hand-off, sets
// up the course, then walks one unit position per cycle (up to
// MAX_UNITS_PER_COURSE) unless a found unit waits on a stalled output, and
// closes the course. Each found unit waits in a pending register until the
// next unit or the end of the course shows whether it is the last, then moves
// to the output register. A failed check or a reached cap gives its status
// result straight after the checks; an above-wall result comes after course
// setup. A stalled output holds the walk and the close. Input stall is high
// from acceptance until the final result for that item enters the output
// register.
module brick_bond_course_walker_unit
	import bbcw_pkg::*;
#(
	parameter int MAX_UNITS_PER_COURSE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_wr_t   cfg
);
	localparam int IW = (MAX_UNITS_PER_COURSE > 1) ? $clog2(MAX_UNITS_PER_COURSE) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SETUP = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [1:0]  bond_q;
	logic [15:0] len_q, hgt_q, dep_q, jnt_q, maxu_q;
	logic [15:0] units_q;
	logic        cap_q;
	logic [2:0]  state_q;
	in_item_t    item_q;
	logic [IW:0] idx_q;
	logic signed [19:0] x_q;
	logic signed [19:0] y_q;
	out_item_t   pend_q;
	logic        pend_v_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	logic bad_ext, bad_unit, chk_stat;
	assign bad_ext  = (item_q.wall_half_length <= 15'd1) || (item_q.wall_half_height <= 15'd1)
		|| (item_q.wall_half_depth <= 15'd1);
	assign bad_unit = (len_q <= 16'd1) || (hgt_q <= 16'd1) || (dep_q <= 16'd1);
	assign chk_stat = bad_ext || bad_unit || cap_q;

	bbcw_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign dreq = '{start: (state_q == S_CHECK) && !chk_stat,
		dividend: {item_q.wall_half_height, 1'b0},
		divisor: {1'b0, hgt_q} + {1'b0, jnt_q}};

	// walk datapath
	logic signed [19:0] hl, face, xend, cs, ce, clen;
	logic hdr, odd;
	assign hl   = 20'(item_q.wall_half_length);
	assign odd  = item_q.course_number[0];
	assign hdr  = (bond_q == BOND_FLEMISH) ? idx_q[0] : ((bond_q == BOND_ENGLISH) && odd);
	assign face = hdr ? 20'(dep_q) : 20'(len_q);
	assign xend = x_q + face;
	assign cs   = (x_q > -hl) ? x_q : -hl;
	assign ce   = (xend < hl) ? xend : hl;
	assign clen = ce - cs;

	logic [17:0] shamt;
	always_comb begin
		unique case (bond_q)
			BOND_RUNNING: shamt = {2'b0, len_q} + {2'b0, jnt_q};
			BOND_ENGLISH: shamt = {2'b0, dep_q} + {2'b0, jnt_q};
			BOND_FLEMISH: shamt = {2'b0, len_q} + {2'b0, dep_q} + {1'b0, jnt_q, 1'b0};
			default:      shamt = '0;
		endcase
	end

	logic [15:0] units_inc;
	assign units_inc = (units_q != 16'hFFFF) ? units_q + 16'd1 : units_q;

	logic walk_go, unit_hit, above, out_free, take, step, push;
	assign walk_go  = (idx_q < (IW+1)'(MAX_UNITS_PER_COURSE)) && (x_q < hl - 20'sd1);
	assign unit_hit = walk_go && (clen > 20'sd1);
	assign above    = {4'b0, item_q.course_number} >= drsp.quotient;
	assign out_free = !out_valid || !out_stall;
	// a found unit replaces the pending one, which moves to the output first
	assign take = (state_q == S_WALK) && unit_hit && (!pend_v_q || out_free);
	assign step = (state_q == S_WALK) && walk_go && (!unit_hit || take);
	assign push = ((state_q == S_WALK) && unit_hit && pend_v_q && out_free)
		|| ((state_q == S_FLUSH) && out_free);

	function automatic out_item_t stat_res(input logic [2:0] st, input logic [11:0] c);
		out_item_t r;
		r = '0;
		r.status = st;
		r.course_out = c;
		r.last = 1'b1;
		return r;
	endfunction

	out_item_t unit_res;
	always_comb begin
		unit_res = '0;
		unit_res.status = ST_UNIT;
		unit_res.course_out = item_q.course_number;
		unit_res.unit_index = 6'(idx_q);
		unit_res.span_start = 16'(cs);
		unit_res.span_length = 16'(clen);
		unit_res.center_height = 16'(y_q);
		unit_res.is_header = hdr;
		// the unit that reaches the cap closes the course
		unit_res.last = (units_inc >= maxu_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bond_q <= BOND_RUNNING;
			len_q  <= 16'd880;
			hgt_q  <= 16'd266;
			dep_q  <= 16'd420;
			jnt_q  <= 16'd41;
			maxu_q <= 16'd4096;
		end else if (cfg_valid) begin
			unique case (cfg.index)
				REG_BOND:   bond_q <= cfg.data[1:0];
				REG_LENGTH: len_q  <= cfg.data;
				REG_HEIGHT: hgt_q  <= cfg.data;
				REG_DEPTH:  dep_q  <= cfg.data;
				REG_JOINT:  jnt_q  <= cfg.data;
				REG_MAXU:   maxu_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			units_q   <= '0;
			cap_q     <= 1'b0;
			out_valid <= 1'b0;
			pend_v_q  <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (push) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
						if (in_data.course_number == 12'd0) begin
							units_q <= '0;
							cap_q   <= 1'b0;
						end
					end
				end
				S_CHECK: begin
					if (chk_stat) begin
						pend_v_q <= 1'b1;
						state_q  <= S_FLUSH;
					end else state_q <= S_DIV;
				end
				S_DIV: begin
					if (drsp.done) state_q <= S_SETUP;
				end
				S_SETUP: begin
					idx_q <= '0;
					if (above) begin
						pend_v_q <= 1'b1;
						state_q  <= S_FLUSH;
					end else state_q <= S_WALK;
				end
				S_WALK: begin
					if (!walk_go) begin
						pend_v_q <= 1'b1;
						state_q  <= S_FLUSH;
					end else if (step) begin
						idx_q <= idx_q + (IW+1)'(1);
						if (take) begin
							pend_v_q <= 1'b1;
							units_q  <= units_inc;
							if (units_inc >= maxu_q) begin
								cap_q   <= 1'b1;
								state_q <= S_FLUSH;
							end
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload side
	logic signed [19:0] ybase;
	assign ybase = -20'(item_q.wall_half_height) + 20'(hgt_q >> 1);
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) item_q <= in_data;
		if (state_q == S_CHECK) begin
			y_q <= ybase;
			if (odd) x_q <= -hl - 20'(shamt >> 1);
			else     x_q <= -hl;
			priority if (bad_ext) pend_q <= stat_res(ST_BAD_EXTENT, item_q.course_number);
			else if (bad_unit)    pend_q <= stat_res(ST_BAD_UNIT, item_q.course_number);
			else                  pend_q <= stat_res(ST_CAP, item_q.course_number);
		end
		if (state_q == S_SETUP) begin
			y_q    <= y_q + 20'(item_q.course_number) * 20'(dreq.divisor);
			pend_q <= stat_res(ST_ABOVE, item_q.course_number);
		end
		if (state_q == S_WALK) begin
			if (!walk_go) begin
				// close the course on the pending unit, or report it empty
				if (pend_v_q) pend_q.last <= 1'b1;
				else          pend_q <= stat_res(ST_EMPTY, item_q.course_number);
			end else if (step) begin
				x_q <= xend + 20'(jnt_q);
				if (take) pend_q <= unit_res;
			end
		end
		if (push) out_data <= pend_q;
	end

	`include "assert_macros.svh"
	`CHK_IMPL(a_stall_busy, clk, arst_n, state_q == S_WALK, in_stall)
	`CHK_NEXT(a_cap_sticky, clk, arst_n, cap_q && !(state_q == S_IDLE && in_valid), cap_q)
	`CHK_IMPL(a_div_once, clk, arst_n, drsp.done, state_q == S_DIV)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
